FILE: hdl/cbnt_pkg.sv
// ----------------------------------------------------------------------------
// cbnt_pkg
// Shared types, codes and sizing for the conditional block nesting tracker.
// ----------------------------------------------------------------------------
package cbnt_pkg;

    // stack depth and the width of the level counter
    localparam int MAX_DEPTH = 16;
    localparam int LVL_W     = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;

    // line actions
    localparam logic [2:0] ACT_PLAIN = 3'd0;
    localparam logic [2:0] ACT_IF    = 3'd1;
    localparam logic [2:0] ACT_IFT   = 3'd2;
    localparam logic [2:0] ACT_IFF   = 3'd3;
    localparam logic [2:0] ACT_IFTF  = 3'd4;
    localparam logic [2:0] ACT_ENDC  = 3'd5;
    localparam logic [2:0] ACT_IIF   = 3'd6;

    // relation codes
    localparam logic [3:0] REL_EQ      = 4'd0;
    localparam logic [3:0] REL_NE      = 4'd1;
    localparam logic [3:0] REL_GT      = 4'd2;
    localparam logic [3:0] REL_GE      = 4'd3;
    localparam logic [3:0] REL_LT      = 4'd4;
    localparam logic [3:0] REL_LE      = 4'd5;
    localparam logic [3:0] REL_DF      = 4'd6;
    localparam logic [3:0] REL_NDF     = 4'd7;
    localparam logic [3:0] REL_MISSING = 4'd9;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNMATCHED = 3'd1;
    localparam logic [2:0] ST_TOO_DEEP  = 3'd2;
    localparam logic [2:0] ST_BAD_COND  = 3'd3;
    localparam logic [2:0] ST_NO_SYMBOL = 3'd4;

    // operand sign classes
    localparam logic [2:0] SGN_ZERO = 3'b001;
    localparam logic [2:0] SGN_POS  = 3'b010;
    localparam logic [2:0] SGN_NEG  = 3'b100;

    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         relation;
        logic signed [31:0] operand_value;
        logic               symbol_defined;
    } t_in_item;

    typedef struct packed {
        logic       process_line;
        logic [2:0] status;
        logic       ignoring;
        logic [3:0] nesting_level;
    } t_out_item;

    // outcome of one condition test
    typedef struct packed {
        logic       taken;
        logic [2:0] status;
    } t_cond;

    // sign classes that satisfy a compare relation
    function automatic logic [2:0] rel_sign_mask(input logic [3:0] rel);
        logic [2:0] m;
        m = 3'b000;
        case (rel)
            REL_EQ:  m = SGN_ZERO;
            REL_NE:  m = SGN_POS | SGN_NEG;
            REL_GT:  m = SGN_POS;
            REL_GE:  m = SGN_POS | SGN_ZERO;
            REL_LT:  m = SGN_NEG;
            REL_LE:  m = SGN_NEG | SGN_ZERO;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/cbnt_cond_eval.sv
// ----------------------------------------------------------------------------
// cbnt_cond_eval
// Evaluates the condition of an .if or .iif line: sign test or defined test.
// ----------------------------------------------------------------------------
module cbnt_cond_eval (
    input  cbnt_pkg::t_in_item i_item,
    output cbnt_pkg::t_cond    o_cond
);

    logic [2:0] sgn;

    always_comb begin
        if (i_item.operand_value == 32'sd0) begin
            sgn = cbnt_pkg::SGN_ZERO;
        end else if (i_item.operand_value[31]) begin
            sgn = cbnt_pkg::SGN_NEG;
        end else begin
            sgn = cbnt_pkg::SGN_POS;
        end
    end

    always_comb begin
        o_cond.taken  = 1'b0;
        o_cond.status = cbnt_pkg::ST_OK;
        case (i_item.relation)
            cbnt_pkg::REL_EQ, cbnt_pkg::REL_NE, cbnt_pkg::REL_GT,
            cbnt_pkg::REL_GE, cbnt_pkg::REL_LT, cbnt_pkg::REL_LE: begin
                o_cond.taken = |(cbnt_pkg::rel_sign_mask(i_item.relation) & sgn);
            end
            cbnt_pkg::REL_DF: begin
                o_cond.taken = i_item.symbol_defined;
            end
            cbnt_pkg::REL_NDF: begin
                o_cond.taken = ~i_item.symbol_defined;
            end
            cbnt_pkg::REL_MISSING: begin
                o_cond.status = cbnt_pkg::ST_NO_SYMBOL;
            end
            default: begin
                o_cond.status = cbnt_pkg::ST_BAD_COND;
            end
        endcase
    end

endmodule

FILE: hdl/cbnt_stack.sv
// ----------------------------------------------------------------------------
// cbnt_stack
// Condition stack, nesting level and ignore flag; handles one line per cycle while i_adv is high.
// ----------------------------------------------------------------------------
module cbnt_stack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  cbnt_pkg::t_in_item  i_item,
    input  cbnt_pkg::t_cond     i_cond,
    output cbnt_pkg::t_out_item o_res
);

    localparam logic [cbnt_pkg::LVL_W-1:0] LVL_TOP =
        cbnt_pkg::LVL_W'(cbnt_pkg::MAX_DEPTH - 1);
    localparam logic [cbnt_pkg::LVL_W-1:0] LVL_ONE = cbnt_pkg::LVL_W'(1);

    logic [cbnt_pkg::MAX_DEPTH-1:0] r_blk, n_blk;
    logic [cbnt_pkg::MAX_DEPTH-1:0] r_sub, n_sub;
    logic [cbnt_pkg::LVL_W-1:0]     r_level, n_level;
    logic                           r_ign, n_ign;

    logic [cbnt_pkg::LVL_W-1:0] lvl_up;
    logic [cbnt_pkg::LVL_W-1:0] lvl_dn;
    logic [cbnt_pkg::LVL_W-1:0] sub_idx;
    logic                       at_top;
    logic                       at_bottom;
    logic                       blk_rd;
    logic                       sub_rd;
    logic                       if_val;
    logic                       proc;
    logic [2:0]                 st;

    assign lvl_up    = r_level + LVL_ONE;
    assign lvl_dn    = r_level - LVL_ONE;
    assign at_top    = (r_level == LVL_TOP);
    assign at_bottom = (r_level == '0);
    // endc looks at the subcondition of the level it returns to
    assign sub_idx   = (i_item.action == cbnt_pkg::ACT_ENDC && !at_bottom) ? lvl_dn : r_level;
    assign blk_rd    = r_blk[r_level];
    assign sub_rd    = r_sub[sub_idx];
    // inside an ignored region a new block is false and is not evaluated
    assign if_val    = r_ign ? 1'b0 : i_cond.taken;

    always_comb begin
        n_blk   = r_blk;
        n_sub   = r_sub;
        n_level = r_level;
        n_ign   = r_ign;
        proc    = 1'b0;
        st      = cbnt_pkg::ST_OK;
        case (i_item.action)
            cbnt_pkg::ACT_IF: begin
                if (at_top) begin
                    st = cbnt_pkg::ST_TOO_DEEP;
                end else begin
                    n_level        = lvl_up;
                    n_blk[lvl_up]  = if_val;
                    n_sub[lvl_up]  = if_val;
                    n_ign          = ~if_val;
                    st             = r_ign ? cbnt_pkg::ST_OK : i_cond.status;
                end
            end
            cbnt_pkg::ACT_IFT: begin
                n_sub[r_level] = blk_rd;
                n_ign          = ~blk_rd;
            end
            cbnt_pkg::ACT_IFF: begin
                n_sub[r_level] = ~blk_rd;
                n_ign          = blk_rd;
            end
            cbnt_pkg::ACT_IFTF: begin
                n_sub[r_level] = 1'b1;
                n_ign          = 1'b0;
            end
            cbnt_pkg::ACT_ENDC: begin
                if (at_bottom) begin
                    st = cbnt_pkg::ST_UNMATCHED;
                end else begin
                    n_level = lvl_dn;
                end
                n_ign = ~sub_rd;
            end
            cbnt_pkg::ACT_IIF: begin
                proc = r_ign ? 1'b0 : i_cond.taken;
                st   = r_ign ? cbnt_pkg::ST_OK : i_cond.status;
            end
            default: begin
                proc = ~r_ign;
            end
        endcase
    end

    always_comb begin
        o_res.process_line  = proc;
        o_res.status        = st;
        o_res.ignoring      = n_ign;
        o_res.nesting_level = 4'(n_level);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk   <= cbnt_pkg::MAX_DEPTH'(1);
            r_sub   <= cbnt_pkg::MAX_DEPTH'(1);
            r_level <= '0;
            r_ign   <= 1'b0;
        end else if (i_adv) begin
            r_blk   <= n_blk;
            r_sub   <= n_sub;
            r_level <= n_level;
            r_ign   <= n_ign;
        end
    end

endmodule

FILE: hdl/conditional_block_nesting_tracker_core.sv
// ----------------------------------------------------------------------------
// conditional_block_nesting_tracker_core
// Tracks conditional assembly nesting for a stream of classified lines.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one classified
// line per beat: action, relation, operand value and symbol-defined flag.
// Output channel (o_out_valid / i_out_ready / o_out_data) gives one result
// beat per line: process flag, status, ignore flag and nesting level after
// the line.
// A line passes through the input register, then the stack update and result
// register. Throughput is one line per cycle while the receiver takes results;
// the stack state is updated in the same cycle the result register loads, so
// each line sees the state left by the one before it.
// When the receiver stalls, the result register holds and the input register
// keeps taking one more line; after that o_in_ready drops until the result
// drains.
// Reset empties both registers, sets the level to zero, clears the ignore
// flag and leaves only the outermost stack entry true.
// ----------------------------------------------------------------------------
module conditional_block_nesting_tracker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cbnt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cbnt_pkg::t_out_item o_out_data
);

    logic                r_in_vld;
    cbnt_pkg::t_in_item  r_in;
    logic                r_out_vld;
    cbnt_pkg::t_out_item r_out;

    logic                adv;
    cbnt_pkg::t_cond     cond;
    cbnt_pkg::t_out_item res;

    // line moves from input register into result register
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    cbnt_cond_eval u_cond (
        .i_item (r_in),
        .o_cond (cond)
    );

    cbnt_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_cond  (cond),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: hdl/cbnt_checker.sv
// ----------------------------------------------------------------------------
// cbnt_checker
// Port-level checks for the conditional block nesting tracker.
// ----------------------------------------------------------------------------
module cbnt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input cbnt_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input cbnt_pkg::t_out_item o_out_data
);

    // reset leaves the output side empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // a processed line is never inside an ignored region
    a_proc_not_ign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.process_line |-> !o_out_data.ignoring)
        else $error("line processed while ignoring");

    // unmatched endc only happens at the outermost level
    a_unmatched_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == cbnt_pkg::ST_UNMATCHED
        |-> o_out_data.nesting_level == 4'd0 && !o_out_data.process_line)
        else $error("unmatched endc away from level zero");

    // a refused if leaves the level at the top of the stack
    a_too_deep_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == cbnt_pkg::ST_TOO_DEEP
        |-> o_out_data.nesting_level == 4'(cbnt_pkg::MAX_DEPTH - 1))
        else $error("nesting too deep below the top level");

endmodule

bind conditional_block_nesting_tracker_core cbnt_checker u_cbnt_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the conditional block nesting tracker core.
// Feeds directed and randomized line streams through the valid/ready ports,
// predicts every result beat from its own copy of the nesting stack and checks
// the beats in order under several idle, stall and back-pressure patterns.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // codes the package leaves unnamed
    localparam logic [2:0] ACT_UNKNOWN  = 3'd7;
    localparam logic [3:0] REL_BAD      = 4'd8;
    localparam logic [3:0] REL_BAD_LAST = 4'd15;

    // shapes of the random line stream
    localparam int MODE_DIVE  = 0;
    localparam int MODE_CLIMB = 1;
    localparam int MODE_MIXED = 2;
    localparam int MODE_NOISE = 3;

    localparam int RANDOM_LINES = 1000;
    localparam int HOLD_CYCLES  = 80;

    class nesting_scoreboard;
        bit                  blk_cond[cbnt_pkg::MAX_DEPTH];
        bit                  sub_cond[cbnt_pkg::MAX_DEPTH];
        int                  depth;
        bit                  skipping;
        cbnt_pkg::t_out_item pending_verdicts[$];
        int                  errors;
        int                  checked;
        int                  deepest;
        int                  refusals;

        function new();
            foreach (blk_cond[i]) begin
                blk_cond[i] = 1'b0;
                sub_cond[i] = 1'b0;
            end
            blk_cond[0] = 1'b1;
            sub_cond[0] = 1'b1;
            depth       = 0;
            skipping    = 1'b0;
            errors      = 0;
            checked     = 0;
            deepest     = 0;
            refusals    = 0;
        endfunction

        function bit test_condition(cbnt_pkg::t_in_item it, output logic [2:0] st);
            logic [2:0] sgn;
            st = cbnt_pkg::ST_OK;
            if (it.operand_value == 0) begin
                sgn = cbnt_pkg::SGN_ZERO;
            end else if (it.operand_value[31]) begin
                sgn = cbnt_pkg::SGN_NEG;
            end else begin
                sgn = cbnt_pkg::SGN_POS;
            end
            case (it.relation)
                cbnt_pkg::REL_EQ:      return sgn == cbnt_pkg::SGN_ZERO;
                cbnt_pkg::REL_NE:      return sgn != cbnt_pkg::SGN_ZERO;
                cbnt_pkg::REL_GT:      return sgn == cbnt_pkg::SGN_POS;
                cbnt_pkg::REL_GE:      return sgn != cbnt_pkg::SGN_NEG;
                cbnt_pkg::REL_LT:      return sgn == cbnt_pkg::SGN_NEG;
                cbnt_pkg::REL_LE:      return sgn != cbnt_pkg::SGN_POS;
                cbnt_pkg::REL_DF:      return it.symbol_defined;
                cbnt_pkg::REL_NDF:     return !it.symbol_defined;
                cbnt_pkg::REL_MISSING: begin
                    st = cbnt_pkg::ST_NO_SYMBOL;
                    return 1'b0;
                end
                default: begin
                    st = cbnt_pkg::ST_BAD_COND;
                    return 1'b0;
                end
            endcase
        endfunction

        function cbnt_pkg::t_out_item predict_line(cbnt_pkg::t_in_item it);
            cbnt_pkg::t_out_item r;
            bit                  v;
            logic [2:0]          st;
            r  = '0;
            st = cbnt_pkg::ST_OK;
            case (it.action)
                cbnt_pkg::ACT_IF: begin
                    if (depth >= cbnt_pkg::MAX_DEPTH - 1) begin
                        st = cbnt_pkg::ST_TOO_DEEP;
                        refusals++;
                    end else begin
                        depth++;
                        // a nested block inside a skipped one is never evaluated
                        v = 1'b0;
                        if (!skipping) v = test_condition(it, st);
                        blk_cond[depth] = v;
                        sub_cond[depth] = v;
                        skipping        = !v;
                        if (depth > deepest) deepest = depth;
                    end
                end
                cbnt_pkg::ACT_IFT: begin
                    sub_cond[depth] = blk_cond[depth];
                    skipping        = !sub_cond[depth];
                end
                cbnt_pkg::ACT_IFF: begin
                    sub_cond[depth] = !blk_cond[depth];
                    skipping        = !sub_cond[depth];
                end
                cbnt_pkg::ACT_IFTF: begin
                    sub_cond[depth] = 1'b1;
                    skipping        = 1'b0;
                end
                cbnt_pkg::ACT_ENDC: begin
                    if (depth > 0) depth--;
                    else st = cbnt_pkg::ST_UNMATCHED;
                    skipping = !sub_cond[depth];
                end
                cbnt_pkg::ACT_IIF: begin
                    if (!skipping) r.process_line = test_condition(it, st);
                end
                default: r.process_line = !skipping;
            endcase
            r.status        = st;
            r.ignoring      = skipping;
            r.nesting_level = 4'(depth);
            return r;
        endfunction

        function void log_line(cbnt_pkg::t_in_item it);
            pending_verdicts.push_back(predict_line(it));
        endfunction

        function void cmp_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(cbnt_pkg::t_out_item got);
            cbnt_pkg::t_out_item want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t ns: unexpected result beat, expected none got %h", $time, got);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            checked++;
            cmp_field("process_line", want.process_line, got.process_line);
            cmp_field("status", want.status, got.status);
            cmp_field("ignoring", want.ignoring, got.ignoring);
            cmp_field("nesting_level", want.nesting_level, got.nesting_level);
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                out_ready = 1'b0;
    cbnt_pkg::t_in_item  in_data   = '0;
    logic                in_ready;
    logic                out_valid;
    cbnt_pkg::t_out_item out_data;

    nesting_scoreboard sb;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  pressure_on   = 1'b0;
    bit  pressure_done = 1'b0;
    int  lines_sent    = 0;

    conditional_block_nesting_tracker_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls plus one long hold-off while lines keep coming
    initial begin
        forever begin
            @(negedge clk);
            if (pressure_on && !pressure_done) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                pressure_done = 1'b1;
            end
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_verdict(out_data);
    end

    task automatic send_line(input cbnt_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge clk); while (!in_ready);
        sb.log_line(it);
        lines_sent++;
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [2:0] act, input logic [3:0] rel,
                               input logic [31:0] val, input logic defd);
        cbnt_pkg::t_in_item it;
        it.action         = act;
        it.relation       = rel;
        it.operand_value  = val;
        it.symbol_defined = defd;
        send_line(it);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_action(int if_pct, int endc_pct);
        int r;
        r = $urandom_range(99);
        if (r < if_pct) return cbnt_pkg::ACT_IF;
        if (r < if_pct + endc_pct) return cbnt_pkg::ACT_ENDC;
        case ($urandom_range(5))
            0:       return cbnt_pkg::ACT_IFT;
            1:       return cbnt_pkg::ACT_IFF;
            2:       return cbnt_pkg::ACT_IFTF;
            3:       return cbnt_pkg::ACT_IIF;
            default: return cbnt_pkg::ACT_PLAIN;
        endcase
    endfunction

    function automatic cbnt_pkg::t_in_item make_random_line(int mode);
        cbnt_pkg::t_in_item it;
        case (mode)
            MODE_DIVE:  it.action = pick_action(45, 10);
            MODE_CLIMB: it.action = pick_action(10, 45);
            MODE_MIXED: it.action = pick_action(20, 20);
            default:    it.action = 3'($urandom_range(7));
        endcase
        if (mode == MODE_NOISE) begin
            it.relation = 4'($urandom_range(15));
        end else if ($urandom_range(9) == 0) begin
            it.relation = 4'($urandom_range(REL_BAD_LAST, REL_BAD));
        end else begin
            it.relation = 4'($urandom_range(cbnt_pkg::REL_NDF, cbnt_pkg::REL_EQ));
        end
        it.operand_value  = rand_operand();
        it.symbol_defined = 1'($urandom_range(1));
        return it;
    endfunction

    initial begin
        int mode;
        int seg_left;
        int phase;
        sb       = new();
        seg_left = 0;
        mode     = MODE_DIVE;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed lines: every relation, every directive, each error status but too-deep
        send_fields(cbnt_pkg::ACT_PLAIN, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        // unmatched at top
        send_fields(cbnt_pkg::ACT_ENDC, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IF, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_NE, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_GT, 32'h7FFF_FFFF, 1'b0);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_GE, 32'd0, 1'b1);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_LT, 32'h8000_0000, 1'b0);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_LE, 32'd1, 1'b1);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_DF, 32'd5, 1'b1);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_NDF, 32'd5, 1'b1);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_NDF, 32'hFFFF_FFFF, 1'b0);
        send_fields(cbnt_pkg::ACT_IIF, REL_BAD, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IIF, REL_BAD_LAST, 32'd0, 1'b1);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_MISSING, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IFF, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        // handled as plain
        send_fields(ACT_UNKNOWN, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        // skipped, not evaluated
        send_fields(cbnt_pkg::ACT_IF, REL_BAD, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IIF, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_ENDC, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IFTF, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IFT, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IF, cbnt_pkg::REL_MISSING, 32'd0, 1'b1);
        send_fields(cbnt_pkg::ACT_ENDC, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_IF, REL_BAD, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_ENDC, cbnt_pkg::REL_EQ, 32'd0, 1'b0);
        send_fields(cbnt_pkg::ACT_ENDC, cbnt_pkg::REL_EQ, 32'd0, 1'b0);

        // random part in five traffic phases, the last one with a long hold-off
        for (int n = 0; n < RANDOM_LINES; n++) begin
            if (n % (RANDOM_LINES / 5) == 0) begin
                phase = n / (RANDOM_LINES / 5);
                case (phase)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 80; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 80; end
                    3: begin send_idle_pct = 22; stall_pct = 22; end
                    default: begin
                        send_idle_pct = 0;
                        stall_pct     = 0;
                        pressure_on   = 1'b1;
                    end
                endcase
            end
            if (seg_left == 0) begin
                // mostly nested sequences, a small share of pure noise
                case ($urandom_range(9))
                    0, 1, 2: mode = MODE_DIVE;
                    3, 4, 5: mode = MODE_CLIMB;
                    6, 7, 8: mode = MODE_MIXED;
                    default: mode = MODE_NOISE;
                endcase
                seg_left = $urandom_range(40, 10);
            end
            seg_left--;
            send_line(make_random_line(mode));
        end
        in_valid  = 1'b0;
        stall_pct = 0;

        while (sb.pending_verdicts.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d lines, checked %0d result beats", lines_sent, sb.checked);
        $display("deepest nesting %0d, %0d refused too-deep blocks, %0d errors",
                 sb.deepest, sb.refusals, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
